// File: src/hsv_threshold_blob_centroid_macros.svh
// Assertion macros shared by the HSV threshold centroid block.
`ifndef HSV_THRESHOLD_BLOB_CENTROID_MACROS_SVH
`define HSV_THRESHOLD_BLOB_CENTROID_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define HSVTBC_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("hsv_threshold_blob_centroid: same-cycle check failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define HSVTBC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("hsv_threshold_blob_centroid: next-cycle check failed");
`else
`define HSVTBC_ASSERT_SAME(label, clk, rst, pre, post)
`define HSVTBC_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// File: src/hsvtbc_pkg.sv
// Shared types and constants of the HSV threshold centroid block.
package hsvtbc_pkg;

   localparam int CHAN_BITS = 8;
   localparam int COUNT_BITS = 23;
   localparam int COORD_BITS_DEFAULT = 11;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = COUNT_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [CHAN_BITS-1:0] HUE_LOW_RESET = 8'd15;
   localparam logic [CHAN_BITS-1:0] HUE_HIGH_RESET = 8'd24;
   localparam logic [CHAN_BITS-1:0] SAT_LOW_RESET = 8'd37;
   localparam logic [CHAN_BITS-1:0] SAT_HIGH_RESET = 8'd255;
   localparam logic [CHAN_BITS-1:0] VAL_LOW_RESET = 8'd121;
   localparam logic [CHAN_BITS-1:0] VAL_HIGH_RESET = 8'd255;
   localparam logic [COUNT_BITS-1:0] MIN_AREA_RESET = 23'd500;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_HUE_LOW  = 3'd0,
      REG_HUE_HIGH = 3'd1,
      REG_SAT_LOW  = 3'd2,
      REG_SAT_HIGH = 3'd3,
      REG_VAL_LOW  = 3'd4,
      REG_VAL_HIGH = 3'd5,
      REG_MIN_AREA = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic take;
      logic last;
      logic step;
      logic finish;
   } cmd_type;

endpackage

// File: src/hsvtbc_datapath.sv
// Datapath: thresholds, accumulators, per-axis bit-serial dividers and result register.
module hsvtbc_datapath
   import hsvtbc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   input  cmd_type                   cmd,
   input  logic [CHAN_BITS-1:0]      hue,
   input  logic [CHAN_BITS-1:0]      sat,
   input  logic [CHAN_BITS-1:0]      val,
   input  logic [COORD_BITS-1:0]     pix_x,
   input  logic [COORD_BITS-1:0]     pix_y,
   output logic                      rsp_mask,
   output logic                      rsp_found,
   output logic [COORD_BITS-1:0]     rsp_cx,
   output logic [COORD_BITS-1:0]     rsp_cy
);

   localparam int SUM_BITS = COUNT_BITS + COORD_BITS;

   logic [CHAN_BITS-1:0] hue_low_ff, hue_high_ff, sat_low_ff, sat_high_ff;
   logic [CHAN_BITS-1:0] val_low_ff, val_high_ff;
   logic [COUNT_BITS-1:0] min_area_ff;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SUM_BITS-1:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;

   logic [COUNT_BITS-1:0] divisor_ff;
   logic [COUNT_BITS-1:0] rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [COORD_BITS-1:0] work_x_ff, work_x_in, work_y_ff, work_y_in;
   logic found_ff, found_in;
   logic last_mask_ff;

   logic rsp_mask_ff, rsp_found_ff;
   logic [COORD_BITS-1:0] rsp_cx_ff, rsp_cy_ff;

   logic mask, acc_en;
   logic [COUNT_BITS:0] trial_x, trial_y, divisor_ext;
   logic ge_x, ge_y;

   assign mask = (hue >= hue_low_ff) && (hue <= hue_high_ff) &&
                 (sat >= sat_low_ff) && (sat <= sat_high_ff) &&
                 (val >= val_low_ff) && (val <= val_high_ff);
   assign acc_en = mask && (count_ff != COUNT_MAX);

   always_comb begin
      count_in = count_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      if (acc_en) begin
         count_in = count_ff + 1'b1;
         sum_x_in = sum_x_ff + SUM_BITS'(pix_x);
         sum_y_in = sum_y_ff + SUM_BITS'(pix_y);
      end
      found_in = count_in > min_area_ff;
   end

   assign divisor_ext = {1'b0, divisor_ff};
   assign trial_x = {rem_x_ff, work_x_ff[COORD_BITS-1]};
   assign trial_y = {rem_y_ff, work_y_ff[COORD_BITS-1]};
   assign ge_x = trial_x >= divisor_ext;
   assign ge_y = trial_y >= divisor_ext;

   always_comb begin
      rem_x_in = ge_x ? COUNT_BITS'(trial_x - divisor_ext) : COUNT_BITS'(trial_x);
      rem_y_in = ge_y ? COUNT_BITS'(trial_y - divisor_ext) : COUNT_BITS'(trial_y);
      work_x_in = {work_x_ff[COORD_BITS-2:0], ge_x};
      work_y_in = {work_y_ff[COORD_BITS-2:0], ge_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff <= HUE_LOW_RESET;
         hue_high_ff <= HUE_HIGH_RESET;
         sat_low_ff <= SAT_LOW_RESET;
         sat_high_ff <= SAT_HIGH_RESET;
         val_low_ff <= VAL_LOW_RESET;
         val_high_ff <= VAL_HIGH_RESET;
         min_area_ff <= MIN_AREA_RESET;
         count_ff <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_reg_type'(csr_index))
               REG_HUE_LOW: hue_low_ff <= csr_data[CHAN_BITS-1:0];
               REG_HUE_HIGH: hue_high_ff <= csr_data[CHAN_BITS-1:0];
               REG_SAT_LOW: sat_low_ff <= csr_data[CHAN_BITS-1:0];
               REG_SAT_HIGH: sat_high_ff <= csr_data[CHAN_BITS-1:0];
               REG_VAL_LOW: val_low_ff <= csr_data[CHAN_BITS-1:0];
               REG_VAL_HIGH: val_high_ff <= csr_data[CHAN_BITS-1:0];
               REG_MIN_AREA: min_area_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.take) begin
            if (cmd.last) begin
               count_ff <= '0;
               sum_x_ff <= '0;
               sum_y_ff <= '0;
            end else begin
               count_ff <= count_in;
               sum_x_ff <= sum_x_in;
               sum_y_ff <= sum_y_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         if (cmd.last) begin
            divisor_ff <= count_in;
            rem_x_ff <= sum_x_in[SUM_BITS-1:COORD_BITS];
            rem_y_ff <= sum_y_in[SUM_BITS-1:COORD_BITS];
            work_x_ff <= sum_x_in[COORD_BITS-1:0];
            work_y_ff <= sum_y_in[COORD_BITS-1:0];
            found_ff <= found_in;
            last_mask_ff <= mask;
         end else begin
            rsp_mask_ff <= mask;
            rsp_found_ff <= 1'b0;
            rsp_cx_ff <= '0;
            rsp_cy_ff <= '0;
         end
      end
      if (cmd.step) begin
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         work_x_ff <= work_x_in;
         work_y_ff <= work_y_in;
      end
      if (cmd.finish) begin
         rsp_mask_ff <= last_mask_ff;
         rsp_found_ff <= found_ff;
         rsp_cx_ff <= found_ff ? work_x_ff : '0;
         rsp_cy_ff <= found_ff ? work_y_ff : '0;
      end
   end

   assign rsp_mask = rsp_mask_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_cx = rsp_cx_ff;
   assign rsp_cy = rsp_cy_ff;

endmodule

// File: src/hsvtbc_ctrl.sv
// Controller: pixel handshake, frame-end division sequence and result valid.
module hsvtbc_ctrl
   import hsvtbc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_last,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   localparam int STEP_BITS = $clog2(COORD_BITS);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(COORD_BITS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic rsp_valid_ff;
   logic take;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign take = req_valid && req_ready;

   always_comb begin
      cmd.take = take;
      cmd.last = req_last;
      cmd.step = state_ff == ST_DIVIDE;
      cmd.finish = state_ff == ST_DONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  if (req_last) begin
                     rsp_valid_ff <= 1'b0;
                     step_ff <= '0;
                     state_ff <= ST_DIVIDE;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                  end
               end else if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_DIVIDE: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/hsv_threshold_blob_centroid.sv
// Top level of the HSV threshold centroid block: ports, beat packing and checks.
// Each pixel beat is tested against inclusive hue, saturation and value bounds and
// answered by one result beat carrying the mask bit. Pixel beats without tlast stream
// at one pixel per clock while the result side keeps up. The beat with tlast closes
// the frame: the block then stops accepting pixels while one restoring divider per
// axis produces one quotient bit per cycle, and the result beat for that pixel carries
// tlast, object_found and the centroid. Configuration writes are taken in any cycle and
// should be made between frames.
`include "hsv_threshold_blob_centroid_macros.svh"
module hsv_threshold_blob_centroid
   import hsvtbc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   localparam int REQ_DATA_BITS = ((3 * CHAN_BITS + 2 * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((2 + 2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // Fields from bit 0: hue, sat, val, pix_x, pix_y, zero padding.
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                      req_tlast,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // Fields from bit 0: mask, object_found, centroid_x, centroid_y, zero padding.
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                      rsp_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int X_LSB = 3 * CHAN_BITS;
   localparam int Y_LSB = X_LSB + COORD_BITS;

   cmd_type cmd;
   logic rsp_mask, rsp_found;
   logic [COORD_BITS-1:0] rsp_cx, rsp_cy;
   logic frame_ff;

   assign csr_ready = 1'b1;

   hsvtbc_ctrl #(
      .COORD_BITS(COORD_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_last (req_tlast),
      .req_ready(req_tready),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .cmd      (cmd)
   );

   hsvtbc_datapath #(
      .COORD_BITS(COORD_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .csr_write(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .cmd      (cmd),
      .hue      (req_tdata[CHAN_BITS-1:0]),
      .sat      (req_tdata[2*CHAN_BITS-1:CHAN_BITS]),
      .val      (req_tdata[3*CHAN_BITS-1:2*CHAN_BITS]),
      .pix_x    (req_tdata[X_LSB+COORD_BITS-1:X_LSB]),
      .pix_y    (req_tdata[Y_LSB+COORD_BITS-1:Y_LSB]),
      .rsp_mask (rsp_mask),
      .rsp_found(rsp_found),
      .rsp_cx   (rsp_cx),
      .rsp_cy   (rsp_cy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= 1'b0;
      end else if (cmd.take) begin
         frame_ff <= req_tlast;
      end
   end

   assign rsp_tlast = frame_ff;
   assign rsp_tdata = RSP_DATA_BITS'({rsp_cy, rsp_cx, rsp_found, rsp_mask});

   // A new pixel is only taken when the result register is free or draining.
   `HSVTBC_ASSERT_SAME(a_ready_needs_room, clock, reset, req_tready && rsp_tvalid, rsp_tready)
   // The frame-end pixel starts the division, so the next cycle accepts nothing.
   `HSVTBC_ASSERT_NEXT(a_busy_after_last, clock, reset, req_tvalid && req_tready && req_tlast,
      !req_tready && !rsp_tvalid)
   // Only frame-end results may report an object or a centroid.
   `HSVTBC_ASSERT_SAME(a_plain_beat_clean, clock, reset, rsp_tvalid && !rsp_tlast,
      !rsp_found && (rsp_cx == '0) && (rsp_cy == '0))

endmodule
